@@ hw/rtl/i2cbm_pkg.sv @@
package i2cbm_pkg;

  // Bus geometry
  localparam int BYTE_BITS  = 8;
  localparam int PHASE_W    = 6;
  localparam int DIV_W      = 10;
  localparam int TOUT_W     = 8;
  localparam int CFG_DATA_W = 10;

  // Bit phases of a send or read byte (two phases per bit)
  localparam logic [PHASE_W-1:0] BIT_PHASES = PHASE_W'(2 * BYTE_BITS);

  // Wait-ack phase numbers
  localparam logic [PHASE_W-1:0] WA_RELEASE = 6'd0;
  localparam logic [PHASE_W-1:0] WA_CLOCK   = 6'd1;
  localparam logic [PHASE_W-1:0] WA_POLL    = 6'd2;
  localparam logic [PHASE_W-1:0] WA_SETTLE  = 6'd3;
  localparam logic [PHASE_W-1:0] WA_STOP_CK = 6'd4;
  localparam logic [PHASE_W-1:0] WA_STOP_DA = 6'd5;
  localparam logic [PHASE_W-1:0] WA_LOW     = 6'd6;

  // Configuration register indexes
  localparam logic CFG_TICKS_PER_DELAY = 1'b0;
  localparam logic CFG_ACK_TIMEOUT     = 1'b1;

  // Configuration reset values
  localparam logic [DIV_W-1:0]  TICKS_RESET   = 10'd1;
  localparam logic [TOUT_W-1:0] TIMEOUT_RESET = 8'd250;

  // Command codes; idle doubles as the latch's empty mark
  typedef enum logic [2:0] {
    CMD_START   = 3'd0,
    CMD_STOP    = 3'd1,
    CMD_SEND    = 3'd2,
    CMD_WAITACK = 3'd3,
    CMD_READ    = 3'd4,
    CMD_ACK     = 3'd5,
    CMD_NACK    = 3'd6,
    CMD_IDLE    = 3'd7
  } cmd_t;

  // One tick request
  typedef struct packed {
    logic                 cmd_valid;
    logic [2:0]           func;
    logic [BYTE_BITS-1:0] tx_byte;
    logic                 ack_after_read;
    logic                 sda_in;
  } item_t;

  // One tick result
  typedef struct packed {
    logic                 scl_level;
    logic                 sda_level;
    logic                 busy_res;
    logic                 done_res;
    logic [BYTE_BITS-1:0] rx_byte;
    logic                 ack_missing;
  } result_t;

  // Queue status toward the sequencer
  typedef struct packed {
    logic avail;
    logic room;
  } q_stat_t;

endpackage

@@ hw/rtl/i2c_bit_level_master.sv @@
// Tick-level I2C master sequencer.
// Input channel: each request is one bus tick carrying an optional command
// (in_cmd_valid, in_func, in_tx_byte, in_ack_after_read) and the sampled SDA
// level (in_sda_in). A request is taken when in_push is high and in_full low.
// Result channel: one result per request, in order: pin levels, busy, done,
// last received byte and the missing-ack flag. The oldest result shows while
// out_empty is low and leaves on out_pop.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 ticks per
// delay, 1 ack timeout); write only while no request is in flight.
// Throughput: one request per clock while the result queue has room. A
// two-entry request queue feeds the sequencer, which steps one tick per cycle
// while it takes a request, into a two-entry result queue. A request is
// registered in the request queue, and its result in the result queue.
// When the receiver stalls, the result queue fills, the sequencer holds, then
// the request queue fills and in_full rises; nothing is dropped.
// Reset: both queues empty, the bus released high, the sequencer idle,
// ticks per delay 1 and ack timeout 250.
module i2c_bit_level_master (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                              in_cmd_valid,
  input  logic [2:0]                        in_func,
  input  logic [i2cbm_pkg::BYTE_BITS-1:0]   in_tx_byte,
  input  logic                              in_ack_after_read,
  input  logic                              in_sda_in,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic                              out_scl_level,
  output logic                              out_sda_level,
  output logic                              out_busy_res,
  output logic                              out_done_res,
  output logic [i2cbm_pkg::BYTE_BITS-1:0]   out_rx_byte,
  output logic                              out_ack_missing,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [i2cbm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import i2cbm_pkg::*;

  item_t   wr_item, head_item;
  result_t step_res, head_res;
  q_stat_t stat;
  logic    q_avail, q_room;
  logic    take;

  assign wr_item.cmd_valid      = in_cmd_valid;
  assign wr_item.func           = in_func;
  assign wr_item.tx_byte        = in_tx_byte;
  assign wr_item.ack_after_read = in_ack_after_read;
  assign wr_item.sda_in         = in_sda_in;

  assign stat = '{avail: q_avail, room: q_room};

  i2cbm_in_q u_in_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_item (wr_item),
    .full    (in_full),
    .pop     (take),
    .avail   (q_avail),
    .head    (head_item)
  );

  i2cbm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .item      (head_item),
    .take      (take),
    .res       (step_res)
  );

  i2cbm_out_q u_out_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (take),
    .wr_res (step_res),
    .room   (q_room),
    .pop    (out_pop),
    .empty  (out_empty),
    .head   (head_res)
  );

  assign out_scl_level   = head_res.scl_level;
  assign out_sda_level   = head_res.sda_level;
  assign out_busy_res    = head_res.busy_res;
  assign out_done_res    = head_res.done_res;
  assign out_rx_byte     = head_res.rx_byte;
  assign out_ack_missing = head_res.ack_missing;

endmodule

@@ hw/rtl/i2cbm_in_q.sv @@
module i2cbm_in_q (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  i2cbm_pkg::item_t wr_item,
  output logic            full,
  input  logic            pop,
  output logic            avail,
  output i2cbm_pkg::item_t head
);
  import i2cbm_pkg::*;

  item_t      mem_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign avail   = (cnt_r != 2'd0);
  assign head    = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && avail;

  // Advance pointers and count
  always_comb begin
    wptr_nxt = do_push ? ~wptr_r : wptr_r;
    rptr_nxt = do_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Store requests
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wr_item;
    end
  end

endmodule

@@ hw/rtl/i2cbm_out_q.sv @@
module i2cbm_out_q (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  i2cbm_pkg::result_t wr_res,
  output logic              room,
  input  logic              pop,
  output logic              empty,
  output i2cbm_pkg::result_t head
);
  import i2cbm_pkg::*;

  result_t    mem_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign room    = (cnt_r != 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign head    = mem_r[rptr_r];
  assign do_push = push && room;
  assign do_pop  = pop && !empty;

  // Advance pointers and count
  always_comb begin
    wptr_nxt = do_push ? ~wptr_r : wptr_r;
    rptr_nxt = do_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Store results
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wr_res;
    end
  end

endmodule

@@ hw/rtl/i2cbm_seq.sv @@
module i2cbm_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [i2cbm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  i2cbm_pkg::q_stat_t             stat,
  input  i2cbm_pkg::item_t               item,
  output logic                           take,
  output i2cbm_pkg::result_t             res
);
  import i2cbm_pkg::*;

  // Configuration
  logic [DIV_W-1:0]  tpd_r;
  logic [TOUT_W-1:0] ato_r;
  logic [DIV_W-1:0]  period;

  // Sequencer state
  cmd_t                 cmd_r, cmd_nxt;
  logic [PHASE_W-1:0]   phase_r, phase_nxt;
  logic [DIV_W-1:0]     div_r, div_nxt;
  logic [BYTE_BITS-1:0] shift_r, shift_nxt;
  logic [TOUT_W-1:0]    tout_r, tout_nxt;
  logic                 scl_r, scl_nxt;
  logic                 sda_r, sda_nxt;
  logic                 ackc_r, ackc_nxt;
  logic                 ackf_r, ackf_nxt;
  logic [BYTE_BITS-1:0] rxh_r, rxh_nxt;

  logic                 enter, fin, done;
  logic [DIV_W:0]       div_sum;
  logic [PHASE_W-1:0]   q;
  logic [2:0]           bit_sel;

  assign take   = stat.avail && stat.room;
  assign period = (tpd_r == '0) ? DIV_W'(1) : tpd_r;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpd_r <= TICKS_RESET;
      ato_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICKS_PER_DELAY: tpd_r <= cfg_data[DIV_W-1:0];
        CFG_ACK_TIMEOUT:     ato_r <= cfg_data[TOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Step the sequencer by one tick
  always_comb begin
    cmd_nxt   = cmd_r;
    phase_nxt = phase_r;
    div_nxt   = div_r;
    shift_nxt = shift_r;
    tout_nxt  = tout_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ackc_nxt  = ackc_r;
    ackf_nxt  = ackf_r;
    rxh_nxt   = rxh_r;
    enter     = 1'b0;
    fin       = 1'b0;
    done      = 1'b0;
    div_sum   = {1'b0, div_r} + (DIV_W+1)'(1);
    q         = phase_r - BIT_PHASES;
    bit_sel   = 3'd0;

    // Pick the phase to enter on this tick
    if (take) begin
      if (cmd_r == CMD_IDLE) begin
        if (item.cmd_valid && (cmd_t'(item.func) != CMD_IDLE)) begin
          cmd_nxt   = cmd_t'(item.func);
          phase_nxt = '0;
          div_nxt   = '0;
          tout_nxt  = '0;
          shift_nxt = (cmd_t'(item.func) == CMD_SEND) ? item.tx_byte : '0;
          ackc_nxt  = (cmd_t'(item.func) == CMD_READ) ? item.ack_after_read : 1'b0;
          enter     = 1'b1;
        end
      end else if (cmd_r == CMD_WAITACK && phase_r == WA_POLL) begin
        enter = 1'b1;
      end else if (div_sum >= {1'b0, period}) begin
        div_nxt   = '0;
        phase_nxt = phase_r + PHASE_W'(1);
        enter     = 1'b1;
      end else begin
        div_nxt = div_sum[DIV_W-1:0];
      end
    end

    // Apply the pin action of the entered phase
    if (enter) begin
      q       = phase_nxt - BIT_PHASES;
      bit_sel = 3'(BYTE_BITS - 1) - phase_nxt[3:1];
      case (cmd_nxt)
        CMD_START: begin
          case (phase_nxt)
            6'd0:    begin sda_nxt = 1'b1; scl_nxt = 1'b1; end
            6'd1:    sda_nxt = 1'b0;
            6'd2:    scl_nxt = 1'b0;
            default: fin = 1'b1;
          endcase
        end
        CMD_STOP: begin
          case (phase_nxt)
            6'd0:    sda_nxt = 1'b0;
            6'd1:    scl_nxt = 1'b1;
            6'd2:    sda_nxt = 1'b1;
            default: fin = 1'b1;
          endcase
        end
        CMD_SEND: begin
          if (phase_nxt < BIT_PHASES) begin
            if (!phase_nxt[0]) begin
              if (phase_nxt[3:1] != 3'd0) scl_nxt = 1'b0;
              sda_nxt = shift_nxt[bit_sel];
            end else begin
              scl_nxt = 1'b1;
            end
          end else begin
            scl_nxt = 1'b0;
            sda_nxt = 1'b1;
            fin     = 1'b1;
          end
        end
        CMD_READ: begin
          if (phase_nxt < BIT_PHASES) begin
            if (!phase_nxt[0]) begin
              scl_nxt = 1'b1;
            end else begin
              shift_nxt = {shift_nxt[BYTE_BITS-2:0], item.sda_in};
              scl_nxt   = 1'b0;
            end
          end else begin
            // ack or nack tail
            case (q)
              6'd0:    sda_nxt = !ackc_nxt;
              6'd1:    scl_nxt = 1'b1;
              6'd2:    scl_nxt = 1'b0;
              6'd3: begin
                if (ackc_nxt) sda_nxt = 1'b1;
                else fin = 1'b1;
              end
              default: fin = 1'b1;
            endcase
            if (fin) rxh_nxt = shift_nxt;
          end
        end
        CMD_WAITACK: begin
          case (phase_nxt)
            WA_RELEASE: sda_nxt = 1'b1;
            WA_CLOCK:   scl_nxt = 1'b1;
            WA_POLL: begin
              if (!item.sda_in) begin
                ackc_nxt  = 1'b0;
                phase_nxt = WA_SETTLE;
                scl_nxt   = 1'b0;
              end else if (tout_nxt >= ato_r) begin
                ackc_nxt  = 1'b1;
                phase_nxt = WA_SETTLE;
                sda_nxt   = 1'b0;
              end else begin
                tout_nxt = tout_nxt + TOUT_W'(1);
              end
            end
            WA_SETTLE: ;
            default: begin
              if (!ackc_nxt) begin
                ackf_nxt = 1'b0;
                fin      = 1'b1;
              end else begin
                case (phase_nxt)
                  WA_STOP_CK: scl_nxt = 1'b1;
                  WA_STOP_DA: sda_nxt = 1'b1;
                  WA_LOW:     scl_nxt = 1'b0;
                  default: begin
                    ackf_nxt = 1'b1;
                    fin      = 1'b1;
                  end
                endcase
              end
            end
          endcase
        end
        CMD_ACK, CMD_NACK: begin
          case (phase_nxt)
            6'd0:    sda_nxt = (cmd_nxt == CMD_NACK);
            6'd1:    scl_nxt = 1'b1;
            6'd2:    scl_nxt = 1'b0;
            6'd3: begin
              if (cmd_nxt == CMD_ACK) sda_nxt = 1'b1;
              else fin = 1'b1;
            end
            default: fin = 1'b1;
          endcase
        end
        default: fin = 1'b1;
      endcase
    end

    // Drop back to idle when the command finishes
    if (fin) begin
      cmd_nxt   = CMD_IDLE;
      phase_nxt = '0;
      done      = 1'b1;
    end
  end

  // Form the result of this tick
  always_comb begin
    res.scl_level   = scl_nxt;
    res.sda_level   = sda_nxt;
    res.busy_res    = (cmd_nxt != CMD_IDLE);
    res.done_res    = done;
    res.rx_byte     = rxh_nxt;
    res.ack_missing = ackf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r   <= CMD_IDLE;
      phase_r <= '0;
      div_r   <= '0;
      shift_r <= '0;
      tout_r  <= '0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      ackc_r  <= 1'b0;
      ackf_r  <= 1'b0;
      rxh_r   <= '0;
    end else begin
      cmd_r   <= cmd_nxt;
      phase_r <= phase_nxt;
      div_r   <= div_nxt;
      shift_r <= shift_nxt;
      tout_r  <= tout_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      ackc_r  <= ackc_nxt;
      ackf_r  <= ackf_nxt;
      rxh_r   <= rxh_nxt;
    end
  end

endmodule

@@ hw/rtl/i2cbm_checker.sv @@
module i2cbm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_push,
  input logic                              in_full,
  input logic                              out_empty,
  input logic                              out_pop,
  input logic                              out_busy_res,
  input logic                              out_done_res,
  input logic [i2cbm_pkg::BYTE_BITS-1:0]   out_rx_byte,
  input logic                              out_ack_missing
);
  import i2cbm_pkg::*;

  // Reset empties the result queue
  a_reset_empty: assert property (@(posedge clk) !$past(rst_n) |-> out_empty)
    else $error("result queue not empty after reset");

  // A finishing tick leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_done_res |-> !out_busy_res)
    else $error("done and busy together");

  // An accepted request yields a waiting result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_push && !in_full |-> ##2 !out_empty)
    else $error("result missing after accepted request");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_rx_byte)
      && $stable(out_ack_missing))
    else $error("stalled result changed");

endmodule

bind i2c_bit_level_master i2cbm_checker u_i2cbm_checker (.*);
